// ===== sv/imusfd_pkg.sv =====
`timescale 1ns / 1ps

package imusfd_pkg;

  // Frame geometry and byte codes.
  localparam int          FRAME_BYTES  = 22;
  localparam int          CNT_W        = 5;
  localparam logic [4:0]  COUNT_MAX    = 5'd31;
  localparam logic [4:0]  FRAME_MIN    = 5'(FRAME_BYTES);
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;

  // Scale registers.
  localparam int           SCALE_W         = 24;
  localparam logic [23:0]  GYRO_SCALE_RST  = 24'd14641;
  localparam logic [23:0]  ACCEL_SCALE_RST = 24'd54807;
  localparam logic [23:0]  RATE_SCALE_RST  = 24'd213333;

  localparam int           CFG_IDX_W   = 2;
  localparam logic [1:0]   CFG_GYRO    = 2'd0;
  localparam logic [1:0]   CFG_ACCEL   = 2'd1;
  localparam logic [1:0]   CFG_RATE    = 2'd2;

  // Result widths.
  localparam int VEL_W  = 30;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 56;

  // Calculation sequence: one multiply per step, the last step only retires.
  localparam int          STEP_W    = 4;
  localparam logic [3:0]  STEP_LAST = 4'd9;

  typedef enum logic [3:0] {
    OP_VEL_X = 4'd0,
    OP_VEL_Y = 4'd1,
    OP_VEL_Z = 4'd2,
    OP_LIN_X = 4'd3,
    OP_LIN_Y = 4'd4,
    OP_LIN_Z = 4'd5,
    OP_DV_X  = 4'd6,
    OP_DV_Y  = 4'd7,
    OP_DV_Z  = 4'd8
  } op_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } state_t;

  typedef struct packed {
    logic hist_shift;
    logic cnt_clear;
    logic mul_en;
    op_t  op;
    logic store_en;
    logic upd_prev;
  } cmd_t;

  typedef struct packed {
    logic rx_newline;
    logic frame_full;
  } status_t;

endpackage

// ===== sv/imusfd_ctrl.sv =====
`timescale 1ns / 1ps

module imusfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  imusfd_pkg::status_t sts,
  output imusfd_pkg::cmd_t    cmd
);
  import imusfd_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    cmd            = '0;
    cmd.op         = op_t'(step_r);
    cmd.hist_shift = accept && !sts.rx_newline;
    cmd.cnt_clear  = accept && sts.rx_newline;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept && sts.rx_newline && sts.frame_full) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // Results are written straight into the output registers, so the
        // sequence waits until the previous result has been transferred.
        if (!out_valid_r) begin
          cmd.mul_en   = (step_r != STEP_LAST);
          cmd.store_en = (step_r != '0);
          step_nxt     = step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            cmd.upd_prev  = 1'b1;
            out_valid_nxt = 1'b1;
            step_nxt      = '0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/imusfd_dp.sv =====
`timescale 1ns / 1ps

module imusfd_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [23:0]                cfg_data,
  input  imusfd_pkg::cmd_t           cmd,
  output imusfd_pkg::status_t        sts,
  output logic signed [29:0]         out_ang_vel_x,
  output logic signed [29:0]         out_ang_vel_y,
  output logic signed [29:0]         out_ang_vel_z,
  output logic signed [29:0]         out_lin_acc_x,
  output logic signed [29:0]         out_lin_acc_y,
  output logic signed [29:0]         out_lin_acc_z,
  output logic signed [47:0]         out_ang_acc_x,
  output logic signed [47:0]         out_ang_acc_y,
  output logic signed [47:0]         out_ang_acc_z
);
  import imusfd_pkg::*;

  logic [7:0]         hist_r [FRAME_BYTES];
  logic [CNT_W-1:0]   cnt_r;
  logic [SCALE_W-1:0] gyro_scale_r, accel_scale_r, rate_scale_r;
  logic signed [VEL_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [VEL_W-1:0] vel_x_r, vel_y_r, vel_z_r;
  logic signed [VEL_W-1:0] lin_x_r, lin_y_r, lin_z_r;
  logic signed [ACC_W-1:0] dv_x_r, dv_y_r, dv_z_r;
  logic signed [PROD_W-1:0] prod_r;
  op_t                      prod_op_r;

  logic [15:0]             word_raw;
  logic signed [30:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0]  rnd;

  assign sts.rx_newline = (in_rx_byte == NEWLINE_CODE);
  assign sts.frame_full = (cnt_r >= FRAME_MIN);

  // Byte history, oldest at index 0, and the count since the last newline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        hist_r[i] <= '0;
      end
    end else if (cmd.hist_shift) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[FRAME_BYTES-1] <= in_rx_byte;
      if (cnt_r != COUNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.cnt_clear) begin
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_scale_r  <= GYRO_SCALE_RST;
      accel_scale_r <= ACCEL_SCALE_RST;
      rate_scale_r  <= RATE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO:  gyro_scale_r  <= cfg_data;
        CFG_ACCEL: accel_scale_r <= cfg_data;
        CFG_RATE:  rate_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    word_raw = {hist_r[2], hist_r[3]};
    mul_b    = {1'b0, gyro_scale_r};
    case (cmd.op)
      OP_VEL_X: word_raw = {hist_r[2], hist_r[3]};
      OP_VEL_Y: word_raw = {hist_r[4], hist_r[5]};
      OP_VEL_Z: word_raw = {hist_r[6], hist_r[7]};
      OP_LIN_X: word_raw = {hist_r[8], hist_r[9]};
      OP_LIN_Y: word_raw = {hist_r[10], hist_r[11]};
      OP_LIN_Z: word_raw = {hist_r[12], hist_r[13]};
      default:  word_raw = {hist_r[2], hist_r[3]};
    endcase
    mul_a = {{17{word_raw[13]}}, word_raw[13:0]};
    case (cmd.op)
      OP_VEL_X, OP_VEL_Y, OP_VEL_Z: mul_b = {1'b0, gyro_scale_r};
      OP_LIN_X, OP_LIN_Y, OP_LIN_Z: mul_b = {1'b0, accel_scale_r};
      default:                      mul_b = {1'b0, rate_scale_r};
    endcase
    // The negated velocity change is the previous velocity minus the new one.
    case (cmd.op)
      OP_DV_X: mul_a = {prev_x_r[VEL_W-1], prev_x_r} - {vel_x_r[VEL_W-1], vel_x_r};
      OP_DV_Y: mul_a = {prev_y_r[VEL_W-1], prev_y_r} - {vel_y_r[VEL_W-1], vel_y_r};
      OP_DV_Z: mul_a = {prev_z_r[VEL_W-1], prev_z_r} - {vel_z_r[VEL_W-1], vel_z_r};
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r    <= prod_nxt;
      prod_op_r <= cmd.op;
    end
  end

  // Round half up, then drop eight fraction bits.
  assign rnd_sum = prod_r + PROD_W'(128);
  assign rnd     = rnd_sum[PROD_W-1:8];

  always_ff @(posedge clk) begin
    if (cmd.store_en) begin
      case (prod_op_r)
        OP_VEL_X: vel_x_r <= rnd[VEL_W-1:0];
        OP_VEL_Y: vel_y_r <= rnd[VEL_W-1:0];
        OP_VEL_Z: vel_z_r <= rnd[VEL_W-1:0];
        OP_LIN_X: lin_x_r <= rnd[VEL_W-1:0];
        OP_LIN_Y: lin_y_r <= rnd[VEL_W-1:0];
        OP_LIN_Z: lin_z_r <= rnd[VEL_W-1:0];
        OP_DV_X:  dv_x_r  <= rnd;
        OP_DV_Y:  dv_y_r  <= rnd;
        OP_DV_Z:  dv_z_r  <= rnd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
    end else if (cmd.upd_prev) begin
      prev_x_r <= vel_x_r;
      prev_y_r <= vel_y_r;
      prev_z_r <= vel_z_r;
    end
  end

  assign out_ang_vel_x = vel_x_r;
  assign out_ang_vel_y = vel_y_r;
  assign out_ang_vel_z = vel_z_r;
  assign out_lin_acc_x = lin_x_r;
  assign out_lin_acc_y = lin_y_r;
  assign out_lin_acc_z = lin_z_r;
  assign out_ang_acc_x = dv_x_r;
  assign out_ang_acc_y = dv_y_r;
  assign out_ang_acc_z = dv_z_r;

endmodule

// ===== sv/imu_serial_frame_decoder.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------------
// input    | in_valid / in_ready          | in_rx_byte (8 bit)
// result   | out_valid / out_ready        | out_ang_vel_*, out_lin_acc_* (30 bit signed),
//          |                              | out_ang_acc_* (48 bit signed)
// config   | cfg_we (no wait)             | cfg_index (2 bit), cfg_data (24 bit)
//
// A byte that is not a newline, or a newline that ends a short frame, is taken
// without delay, and the next byte can follow at once.
// A newline that ends a full frame starts the calculation sequence on one shared
// 31 x 25 bit multiplier (nine products, then a retire step); in_ready is low
// meanwhile, so no further byte is taken until the sequence is over.
// The sequence writes the output registers directly, so it holds at its start
// while an earlier result has not yet been transferred.
// Reset is synchronous and active low; it clears the history, the byte count,
// the previous velocity and restores the default scales.

module imu_serial_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [29:0] out_ang_vel_x,
  output logic signed [29:0] out_ang_vel_y,
  output logic signed [29:0] out_ang_vel_z,
  output logic signed [29:0] out_lin_acc_x,
  output logic signed [29:0] out_lin_acc_y,
  output logic signed [29:0] out_lin_acc_z,
  output logic signed [47:0] out_ang_acc_x,
  output logic signed [47:0] out_ang_acc_y,
  output logic signed [47:0] out_ang_acc_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import imusfd_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t sts;

  imusfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the byte history, the scale registers, the shared
  // multiplier with its rounding stage and the result registers.
  imusfd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_byte    (in_rx_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_ang_vel_x (out_ang_vel_x),
    .out_ang_vel_y (out_ang_vel_y),
    .out_ang_vel_z (out_ang_vel_z),
    .out_lin_acc_x (out_lin_acc_x),
    .out_lin_acc_y (out_lin_acc_y),
    .out_lin_acc_z (out_lin_acc_z),
    .out_ang_acc_x (out_ang_acc_x),
    .out_ang_acc_y (out_ang_acc_y),
    .out_ang_acc_z (out_ang_acc_z)
  );

endmodule

// ===== tb/sv/imu_serial_frame_decoder_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the serial frame decoder of the inertial sensor.
// Bytes go in over a valid/ready channel and decoded samples come back over
// another. Every byte that the block takes is also run through a local copy
// of the decoder below. That copy predicts the sample that a newline after a
// full frame must produce, and the monitor checks each result transfer
// against the oldest prediction that is still waiting.

module imu_serial_frame_decoder_test;
  import imusfd_pkg::*;

  // This many quiet cycles are enough for the block to finish its calculation
  // sequence before a scale register may change.
  localparam int SETTLE_CYCLES = 24;
  // Slowest correct run: about 1800 bytes, some of them holding the block for its
  // calculation sequence, plus long sender gaps and receiver stalls, plus the long
  // receiver hold-off. The limit is set well above that.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 160;
  localparam int REPORT_MAX    = 10;

  // One decoded sample; axis x sits at index 0 of every array.
  typedef struct packed {
    logic [2:0][ACC_W-1:0] ang_acc;
    logic [2:0][VEL_W-1:0] lin_acc;
    logic [2:0][VEL_W-1:0] ang_vel;
  } imu_sample_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic signed [29:0] out_ang_vel_x;
  logic signed [29:0] out_ang_vel_y;
  logic signed [29:0] out_ang_vel_z;
  logic signed [29:0] out_lin_acc_x;
  logic signed [29:0] out_lin_acc_y;
  logic signed [29:0] out_lin_acc_z;
  logic signed [47:0] out_ang_acc_x;
  logic signed [47:0] out_ang_acc_y;
  logic signed [47:0] out_ang_acc_z;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  imu_serial_frame_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ang_vel_x (out_ang_vel_x),
    .out_ang_vel_y (out_ang_vel_y),
    .out_ang_vel_z (out_ang_vel_z),
    .out_lin_acc_x (out_lin_acc_x),
    .out_lin_acc_y (out_lin_acc_y),
    .out_lin_acc_z (out_lin_acc_z),
    .out_ang_acc_x (out_ang_acc_x),
    .out_ang_acc_y (out_ang_acc_y),
    .out_ang_acc_z (out_ang_acc_z),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Bytes waiting to be offered, and samples the block still owes us.
  logic [7:0]  rx_bytes_pending [$];
  imu_sample_t samples_due [$];

  // Shadow state of the decoder.
  logic [7:0]         shadow_hist [FRAME_BYTES];
  logic [CNT_W-1:0]   shadow_count;
  longint             shadow_prev_vel [3];
  logic [SCALE_W-1:0] shadow_gyro_scale;
  logic [SCALE_W-1:0] shadow_accel_scale;
  logic [SCALE_W-1:0] shadow_rate_scale;

  // Idling knobs, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Long receiver hold-off: the stimulus raises the request, the hold
  // process below counts the cycles.
  bit hold_req;
  int hold_left;

  int     mismatch_count;
  int     cycle_count;
  string  axis_name [3] = '{"x", "y", "z"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Signed 14-bit word from the history, big-endian. The two top bits of the
  // first byte are not part of the word.
  function automatic longint frame_word(int off);
    logic signed [13:0] raw;
    raw = {shadow_hist[off][5:0], shadow_hist[off+1]};
    return longint'(raw);
  endfunction

  // Multiply-and-round as the block does it: add half an LSB, then floor.
  function automatic longint scale_round(longint value, logic [SCALE_W-1:0] scale);
    longint prod;
    prod = value * longint'(scale);
    return (prod + 128) >>> 8;
  endfunction

  // Feed one accepted byte to the shadow decoder. A newline after a full
  // frame queues the sample that the block must return for it.
  function automatic void decode_byte(logic [7:0] b);
    imu_sample_t s;
    longint      vel;
    longint      lin;
    longint      dacc;
    if (b != NEWLINE_CODE) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) shadow_hist[i] = shadow_hist[i+1];
      shadow_hist[FRAME_BYTES-1] = b;
      if (shadow_count != COUNT_MAX) shadow_count++;
    end else if (shadow_count < FRAME_MIN) begin
      // A short frame only clears the count; the previous velocity stays.
      shadow_count = '0;
    end else begin
      shadow_count = '0;
      for (int k = 0; k < 3; k++) begin
        vel  = scale_round(frame_word(2 + 2 * k), shadow_gyro_scale);
        lin  = scale_round(frame_word(8 + 2 * k), shadow_accel_scale);
        dacc = scale_round(-(vel - shadow_prev_vel[k]), shadow_rate_scale);
        shadow_prev_vel[k] = vel;
        s.ang_vel[k] = vel[VEL_W-1:0];
        s.lin_acc[k] = lin[VEL_W-1:0];
        s.ang_acc[k] = dacc[ACC_W-1:0];
      end
      samples_due.push_back(s);
    end
  endfunction

  function automatic void report(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endfunction

  // Frame content that is not a newline. Half of the time a byte leans toward the
  // values that put a word at its largest, smallest, zero or sign boundary.
  function automatic logic [7:0] content_byte();
    logic [7:0] v;
    do begin
      case ($urandom_range(7))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = {2'($urandom_range(3)), 6'h1F};
        3:       v = {2'($urandom_range(3)), 6'h20};
        default: v = 8'($urandom_range(255));
      endcase
    end while (v == NEWLINE_CODE);
    return v;
  endfunction

  // Queue nbytes of frame content followed by a newline.
  task automatic queue_frame(int nbytes);
    for (int i = 0; i < nbytes; i++) rx_bytes_pending.push_back(content_byte());
    rx_bytes_pending.push_back(NEWLINE_CODE);
  endtask

  // Queue a frame whose six words all carry the same 14-bit value, with the
  // given pattern in the two unused top bits.
  task automatic queue_word_frame(logic [13:0] word, logic [1:0] top);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i >= 2 && i < 14) begin
        rx_bytes_pending.push_back((i % 2 == 0) ? {top, word[13:8]} : word[7:0]);
      end else begin
        rx_bytes_pending.push_back(content_byte());
      end
    end
    rx_bytes_pending.push_back(NEWLINE_CODE);
  endtask

  // Random traffic: mostly well-formed frames, some longer than a frame,
  // some short, and a little raw noise that may hold newlines anywhere.
  task automatic queue_random_bytes(int budget);
    int before_size;
    int sel;
    before_size = rx_bytes_pending.size();
    while (rx_bytes_pending.size() - before_size < budget) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        queue_frame(FRAME_BYTES);
      end else if (sel < 80) begin
        queue_frame($urandom_range(40, FRAME_BYTES + 1));
      end else if (sel < 90) begin
        queue_frame($urandom_range(FRAME_BYTES - 1, 0));
      end else begin
        repeat ($urandom_range(10, 1)) rx_bytes_pending.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Wait until every byte has been taken and every sample has come back,
  // then give the block time to finish any work that has no result.
  task automatic wait_until_quiet();
    do @(negedge clk);
    while (rx_bytes_pending.size() != 0 || in_valid || samples_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is quiet.
  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_GYRO:  shadow_gyro_scale  = value;
      CFG_ACCEL: shadow_accel_scale = value;
      CFG_RATE:  shadow_rate_scale  = value;
      default: ;
    endcase
  endtask

  task automatic set_scales(logic [23:0] gyro, logic [23:0] accel, logic [23:0] rate);
    write_reg(CFG_GYRO, gyro);
    write_reg(CFG_ACCEL, accel);
    write_reg(CFG_RATE, rate);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // Driver: offers the next pending byte and keeps it steady until the
  // transfer. Each transferred byte goes to the shadow decoder at once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Counts down the long receiver hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every result transfer against the oldest prediction,
  // field by field, and decides the ready for the next cycle.
  always @(posedge clk) begin
    imu_sample_t got;
    imu_sample_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.ang_vel = {out_ang_vel_z, out_ang_vel_y, out_ang_vel_x};
        got.lin_acc = {out_lin_acc_z, out_lin_acc_y, out_lin_acc_x};
        got.ang_acc = {out_ang_acc_z, out_ang_acc_y, out_ang_acc_x};
        if (samples_due.size() == 0) begin
          report("result transfer with no sample expected");
        end else begin
          want = samples_due.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (got.ang_vel[k] !== want.ang_vel[k])
              report($sformatf("ang_vel_%s expected %0d, got %0d", axis_name[k],
                               $signed(want.ang_vel[k]), $signed(got.ang_vel[k])));
            if (got.lin_acc[k] !== want.lin_acc[k])
              report($sformatf("lin_acc_%s expected %0d, got %0d", axis_name[k],
                               $signed(want.lin_acc[k]), $signed(got.lin_acc[k])));
            if (got.ang_acc[k] !== want.ang_acc[k])
              report($sformatf("ang_acc_%s expected %0d, got %0d", axis_name[k],
                               $signed(want.ang_acc[k]), $signed(got.ang_acc[k])));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GYRO;
    cfg_data     = '0;
    hold_req     = 1'b0;
    hold_left    = 0;
    mismatch_count = 0;
    cycle_count  = 0;
    foreach (shadow_hist[i]) shadow_hist[i] = '0;
    foreach (shadow_prev_vel[k]) shadow_prev_vel[k] = 0;
    shadow_count       = '0;
    shadow_gyro_scale  = GYRO_SCALE_RST;
    shadow_accel_scale = ACCEL_SCALE_RST;
    shadow_rate_scale  = RATE_SCALE_RST;
    set_idling(0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the scales left at their reset values. A lone
    // newline right after reset ends an empty frame and gives nothing.
    rx_bytes_pending.push_back(NEWLINE_CODE);
    // Largest positive words with junk in the unused top bits, then the most
    // negative words, then zero words.
    queue_word_frame(14'h1FFF, 2'b11);
    queue_word_frame(14'h2000, 2'b10);
    queue_word_frame(14'h0000, 2'b01);
    // One byte short of a frame: no result and the previous velocity stays.
    queue_frame(FRAME_BYTES - 1);
    // A frame long enough to saturate the byte count; only its tail counts.
    queue_frame(COUNT_MAX + 6);
    queue_word_frame(14'h3FFF, 2'b00);
    wait_until_quiet();

    // Random phases, each with its own scales and one of four idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_scales(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: set_scales(24'h000000, 24'h000000, 24'h000000);
        2: set_scales(24'($urandom), 24'($urandom), 24'($urandom));
        3: begin
          // Index three names no register, so the write must change nothing.
          write_reg(2'd3, 24'($urandom));
          set_scales(24'd1, 24'($urandom), 24'hFFFFFF);
        end
        4: set_scales(GYRO_SCALE_RST, ACCEL_SCALE_RST, RATE_SCALE_RST);
        6: set_scales(24'hFFFFFF, 24'h000000, 24'($urandom));
        default: set_scales(24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      set_idling(ph % 4);
      queue_random_bytes(PHASE_BYTES);
      wait_until_quiet();
    end

    // The receiver holds off for a long stretch while the sender keeps going,
    // so a finished sample blocks the next frame and the input stalls.
    set_idling(0);
    @(negedge clk);
    hold_req = 1'b1;
    repeat (8) queue_frame(FRAME_BYTES);
    wait_until_quiet();

    // The sender stops after each frame until its sample has come back.
    set_idling(3);
    repeat (4) begin
      queue_frame(FRAME_BYTES);
      wait_until_quiet();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
